@@ design/sba_pkg.sv @@
`timescale 1ns / 1ps
package sba_pkg;

  localparam int FRAME_MAX_WIDTH  = 256;
  localparam int FRAME_MAX_HEIGHT = 256;

  localparam int X_W    = $clog2(FRAME_MAX_WIDTH);
  localparam int Y_W    = $clog2(FRAME_MAX_HEIGHT);
  localparam int ADDR_W = $clog2(FRAME_MAX_WIDTH * FRAME_MAX_HEIGHT);

  // Frame size registers are 9 bits; the active size after clamping can reach 256.
  localparam int FSZ_W = 9;
  localparam int ACT_W = 13;
  // Signed working width for clipping and window arithmetic.
  localparam int CW    = 15;

  localparam int PIX_W = 32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_SRC   = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SKIP  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_COPY  = 2'd1,
    MODE_BLEND = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_MEM  = 2'd2
  } state_t;

  typedef struct packed {
    req_t              req_type;
    logic [11:0]       win_src_x;
    logic [11:0]       win_src_y;
    logic [11:0]       win_width;
    logic [11:0]       win_height;
    logic [12:0]       win_dst_x;
    logic [12:0]       win_dst_y;
    logic              blend_enable;
    logic              sprite_has_alpha;
    logic [11:0]       pixel_x;
    logic [11:0]       pixel_y;
    logic [PIX_W-1:0]  pixel_value;
  } item_t;

  // Window decisions handed from the window unit to the sequencer.
  typedef struct packed {
    logic              empty;
    logic              hit;
    logic              blend;
    logic [ADDR_W-1:0] addr;
  } win_info_t;

endpackage

@@ design/sba_frame_ram.sv @@
`timescale 1ns / 1ps
module sba_frame_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/sba_blend.sv @@
`timescale 1ns / 1ps
module sba_blend
  import sba_pkg::*;
(
  input  logic [PIX_W-1:0] src,
  input  logic [PIX_W-1:0] dst,
  output logic [PIX_W-1:0] res
);

  logic [8:0] inv;

  assign inv = 9'd256 - {1'b0, src[31:24]};

  // Premultiplied over on the three colour channels; destination alpha is kept.
  always_comb begin
    logic [16:0] prod;
    res = {dst[31:24], 24'd0};
    for (int c = 0; c < 3; c++) begin
      prod = 17'({1'b0, dst[c*8 +: 8]}) * 17'(inv);
      res[c*8 +: 8] = src[c*8 +: 8] + prod[15:8];
    end
  end

endmodule

@@ design/sba_window.sv @@
`timescale 1ns / 1ps
module sba_window
  import sba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  item_t            item,
  input  logic [ACT_W-1:0] act_w,
  input  logic [ACT_W-1:0] act_h,
  input  logic             commit,
  output win_info_t        info
);

  logic [12:0]    clip_src_x_r, clip_src_y_r;
  logic [11:0]    clip_width_r, clip_height_r;
  logic [X_W-1:0] clip_dst_x_r;
  logic [Y_W-1:0] clip_dst_y_r;
  mode_t          mode_r;

  logic signed [CW-1:0] fw_s, fh_s;
  logic signed [CW-1:0] sx0, sy0, w0, h0, dx0, dy0;
  logic signed [CW-1:0] sx1, sy1, w1, h1, dx1, dy1;
  logic signed [CW-1:0] w2, h2;
  logic signed [CW-1:0] ox, oy, tx, ty;
  logic                 in_win;

  assign fw_s = $signed({{(CW-ACT_W){1'b0}}, act_w});
  assign fh_s = $signed({{(CW-ACT_W){1'b0}}, act_h});

  // Clipping of a new window: negative corners pull the source start in,
  // then the size is cut at the right and bottom frame edges.
  always_comb begin
    sx0 = $signed({3'd0, item.win_src_x});
    sy0 = $signed({3'd0, item.win_src_y});
    w0  = $signed({3'd0, item.win_width});
    h0  = $signed({3'd0, item.win_height});
    dx0 = $signed({{2{item.win_dst_x[12]}}, item.win_dst_x});
    dy0 = $signed({{2{item.win_dst_y[12]}}, item.win_dst_y});
    sx1 = sx0; w1 = w0; dx1 = dx0;
    sy1 = sy0; h1 = h0; dy1 = dy0;
    if (dx0 < 0) begin
      sx1 = sx0 - dx0;
      w1  = w0 + dx0;
      dx1 = '0;
    end
    if (dy0 < 0) begin
      sy1 = sy0 - dy0;
      h1  = h0 + dy0;
      dy1 = '0;
    end
    w2 = (dx1 + w1 > fw_s) ? fw_s - dx1 : w1;
    h2 = (dy1 + h1 > fh_s) ? fh_s - dy1 : h1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_src_x_r  <= '0;
      clip_src_y_r  <= '0;
      clip_width_r  <= '0;
      clip_height_r <= '0;
      clip_dst_x_r  <= '0;
      clip_dst_y_r  <= '0;
      mode_r        <= MODE_NONE;
    end else if (commit) begin
      if (info.empty) begin
        mode_r <= MODE_NONE;
      end else begin
        clip_src_x_r  <= sx1[12:0];
        clip_src_y_r  <= sy1[12:0];
        clip_width_r  <= w2[11:0];
        clip_height_r <= h2[11:0];
        clip_dst_x_r  <= dx1[X_W-1:0];
        clip_dst_y_r  <= dy1[Y_W-1:0];
        mode_r        <= (item.blend_enable && item.sprite_has_alpha) ? MODE_BLEND
                                                                      : MODE_COPY;
      end
    end
  end

  // Mapping of a source pixel into the frame through the recorded window.
  always_comb begin
    ox = $signed({3'd0, item.pixel_x}) - $signed({2'd0, clip_src_x_r});
    oy = $signed({3'd0, item.pixel_y}) - $signed({2'd0, clip_src_y_r});
    tx = $signed({{(CW-X_W){1'b0}}, clip_dst_x_r}) + ox;
    ty = $signed({{(CW-Y_W){1'b0}}, clip_dst_y_r}) + oy;
    in_win = (mode_r != MODE_NONE) && (ox >= 0) && (oy >= 0) &&
             (ox < $signed({3'd0, clip_width_r})) &&
             (oy < $signed({3'd0, clip_height_r}));
  end

  assign info.empty = (w2 <= 0) || (h2 <= 0);
  assign info.hit   = in_win && (tx < fw_s) && (ty < fh_s);
  assign info.blend = (mode_r == MODE_BLEND);
  assign info.addr  = ADDR_W'(ty[Y_W-1:0]) * ADDR_W'(FRAME_MAX_WIDTH) +
                      ADDR_W'(tx[X_W-1:0]);

endmodule

@@ design/sprite_blit_alpha_clip_unit.sv @@
`timescale 1ns / 1ps
// Sprite blitter over an internal frame store of FRAME_MAX_WIDTH x FRAME_MAX_HEIGHT
// 32-bit pixels, with premultiplied alpha blending and window clipping.
// The input stream carries one request per beat, its kind on in_tuser: begin a
// blit (clip and record a window), a source pixel, a frame pixel write or a frame
// pixel read. Each request gives exactly one result beat: status on out_tuser and
// the read pixel (zero for anything but a read) on out_tdata.
// Frame width and height are written through the APB port (byte addresses 0 and
// 4) while the block is idle, a rule on the user that the block does not enforce;
// both reset to 256 and are clamped to the store. Requests are handled one at a
// time. A request without a frame store read goes from idle to execution and back;
// a frame read or a blend adds a memory state for the store's registered read port.
// The result sits in an output register, so the block returns to idle while a
// result still waits; if the receiver stalls with a result pending, the next
// request is held in execution or in the memory state until the register frees.
// Reset is synchronous, active low; it clears the window, the control state and
// the output valid. The frame store itself is not cleared and must be written
// before it is read.
module sprite_blit_alpha_clip_unit
  import sba_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Request beat.
  input  logic         in_tvalid,
  output logic         in_tready,
  // win_src_x[11:0], win_src_y[23:12], win_width[35:24], win_height[47:36],
  // win_dst_x[60:48], win_dst_y[73:61], blend_enable[74], sprite_has_alpha[75],
  // pixel_x[87:76], pixel_y[99:88], pixel_value[131:100], zero fill[135:132]
  input  logic [135:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]   in_tuser,
  // Result beat.
  output logic         out_tvalid,
  input  logic         out_tready,
  // read_value[31:0]
  output logic [31:0]  out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser,
  // Configuration.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  state_t             state_r, state_nxt;
  item_t              item_r;
  logic [FSZ_W-1:0]   frame_width_r, frame_height_r;
  logic [ACT_W-1:0]   act_w, act_h;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [PIX_W-1:0]   out_data_r;

  win_info_t          win;
  logic               commit;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_addr, frame_addr;
  logic [PIX_W-1:0]   ram_wdata, ram_q, blended;
  logic               load;
  status_t            load_status;
  logic [PIX_W-1:0]   load_data;
  logic               out_free, frame_in_range, cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FSZ_W'(256);
      frame_height_r <= FSZ_W'(256);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        frame_height_r <= pwdata[FSZ_W-1:0];
      end else begin
        frame_width_r <= pwdata[FSZ_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {{(32-FSZ_W){1'b0}}, frame_height_r}
                           : {{(32-FSZ_W){1'b0}}, frame_width_r};

  always_comb begin
    if (frame_width_r == '0) begin
      act_w = ACT_W'(1);
    end else if (ACT_W'(frame_width_r) > ACT_W'(FRAME_MAX_WIDTH)) begin
      act_w = ACT_W'(FRAME_MAX_WIDTH);
    end else begin
      act_w = ACT_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      act_h = ACT_W'(1);
    end else if (ACT_W'(frame_height_r) > ACT_W'(FRAME_MAX_HEIGHT)) begin
      act_h = ACT_W'(FRAME_MAX_HEIGHT);
    end else begin
      act_h = ACT_W'(frame_height_r);
    end
  end

  // Request capture.
  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type         <= req_t'(in_tuser);
      item_r.win_src_x        <= in_tdata[11:0];
      item_r.win_src_y        <= in_tdata[23:12];
      item_r.win_width        <= in_tdata[35:24];
      item_r.win_height       <= in_tdata[47:36];
      item_r.win_dst_x        <= in_tdata[60:48];
      item_r.win_dst_y        <= in_tdata[73:61];
      item_r.blend_enable     <= in_tdata[74];
      item_r.sprite_has_alpha <= in_tdata[75];
      item_r.pixel_x          <= in_tdata[87:76];
      item_r.pixel_y          <= in_tdata[99:88];
      item_r.pixel_value      <= in_tdata[131:100];
    end
  end

  sba_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item_r),
    .act_w  (act_w),
    .act_h  (act_h),
    .commit (commit),
    .info   (win)
  );

  assign frame_in_range = ({1'b0, item_r.pixel_x} < act_w) &&
                          ({1'b0, item_r.pixel_y} < act_h);
  assign frame_addr = ADDR_W'(item_r.pixel_y[Y_W-1:0]) * ADDR_W'(FRAME_MAX_WIDTH) +
                      ADDR_W'(item_r.pixel_x[X_W-1:0]);
  assign ram_addr   = (item_r.req_type == REQ_SRC) ? win.addr : frame_addr;

  sba_frame_ram #(
    .DATA_W (PIX_W),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  sba_blend u_blend (
    .src (item_r.pixel_value),
    .dst (ram_q),
    .res (blended)
  );

  assign out_free = !out_valid_r || out_tready;

  // Sequencer: frame writes and window updates happen only in the cycle the result
  // is loaded, so a stalled output never repeats a write or a window update.
  always_comb begin
    state_nxt   = state_r;
    commit      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = item_r.pixel_value;
    load        = 1'b0;
    load_status = STAT_OK;
    load_data   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (item_r.req_type)
          REQ_BEGIN: begin
            load_status = win.empty ? STAT_EMPTY : STAT_OK;
            load        = out_free;
            commit      = out_free;
          end
          REQ_SRC: begin
            if (!win.hit) begin
              load_status = STAT_SKIP;
              load        = out_free;
            end else if (!win.blend || item_r.pixel_value[31:24] == ALPHA_OPAQUE) begin
              load   = out_free;
              ram_we = out_free;
            end else if (item_r.pixel_value[31:24] == ALPHA_CLEAR) begin
              load_status = STAT_SKIP;
              load        = out_free;
            end else begin
              ram_re    = 1'b1;
              state_nxt = ST_MEM;
            end
          end
          REQ_WRITE: begin
            if (!frame_in_range) begin
              load_status = STAT_SKIP;
            end
            load   = out_free;
            ram_we = out_free && frame_in_range;
          end
          REQ_READ: begin
            if (!frame_in_range) begin
              load_status = STAT_SKIP;
              load        = out_free;
            end else begin
              ram_re    = 1'b1;
              state_nxt = ST_MEM;
            end
          end
          default: begin
            load_status = STAT_SKIP;
            load        = out_free;
          end
        endcase
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MEM: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
          if (item_r.req_type == REQ_READ) begin
            load_data = ram_q;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = blended;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= load_status;
      out_data_r   <= load_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/sba_checker.sv @@
`timescale 1ns / 1ps
module sba_checker
  import sba_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // No result beat is offered in the cycle after a reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // Requests are handled one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  // Only a successful read carries pixel data; every other result is zero.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_OK |-> out_tdata == '0)
    else $error("non-zero data on a skipped or empty result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == STAT_OK || out_tuser == STAT_SKIP ||
                   out_tuser == STAT_EMPTY)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind sprite_blit_alpha_clip_unit sba_checker u_sba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ verif/blit_outcome_checker.sv @@
`timescale 1ns / 1ps
module blit_outcome_checker
  import sba_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         run_done,
  output int           mismatches
);

  localparam logic [2:0] FRAME_W_ADDR = 3'd0;
  localparam logic [2:0] FRAME_H_ADDR = 3'd4;

  typedef struct packed {
    logic [3:0]  fill;
    logic [31:0] pixel_value;
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
    logic        sprite_has_alpha;
    logic        blend_enable;
    logic [12:0] win_dst_y;
    logic [12:0] win_dst_x;
    logic [11:0] win_height;
    logic [11:0] win_width;
    logic [11:0] win_src_y;
    logic [11:0] win_src_x;
  } beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] pixel;
  } outcome_t;

  bit   [31:0] frame_img [FRAME_MAX_WIDTH*FRAME_MAX_HEIGHT];
  logic [8:0]  frame_w_reg = 9'd256;
  logic [8:0]  frame_h_reg = 9'd256;
  logic [12:0] clip_sx = '0;
  logic [12:0] clip_sy = '0;
  logic [11:0] clip_w  = '0;
  logic [11:0] clip_h  = '0;
  logic [7:0]  clip_dx = '0;
  logic [7:0]  clip_dy = '0;
  mode_t       win_mode = MODE_NONE;
  outcome_t    pending_outcomes [$];

  initial mismatches = 0;

  task automatic flag_mismatch(string what);
    if (mismatches < 40) $display("[%0t] blit check: %s", $time, what);
    mismatches++;
  endtask

  // Works out the result of one request beat and updates the frame image.
  function automatic outcome_t predict_outcome(req_t kind, beat_t b);
    outcome_t    res;
    int          fw, fh, px, py, sx, sy, ww, hh, dx, dy, ox, oy, tx, ty, slot, inv;
    logic [7:0]  a;
    logic [31:0] old_pix, mixed;
    res.status = STAT_OK;
    res.pixel  = '0;
    fw = (frame_w_reg == 0) ? 1 :
         ((frame_w_reg > FRAME_MAX_WIDTH) ? FRAME_MAX_WIDTH : int'(frame_w_reg));
    fh = (frame_h_reg == 0) ? 1 :
         ((frame_h_reg > FRAME_MAX_HEIGHT) ? FRAME_MAX_HEIGHT : int'(frame_h_reg));
    px = int'(b.pixel_x);
    py = int'(b.pixel_y);
    case (kind)
      REQ_BEGIN: begin
        sx = int'(b.win_src_x);
        sy = int'(b.win_src_y);
        ww = int'(b.win_width);
        hh = int'(b.win_height);
        dx = $signed(b.win_dst_x);
        dy = $signed(b.win_dst_y);
        // A corner left of or above the frame eats into the window from that side.
        if (dx < 0) begin
          sx -= dx;
          ww += dx;
          dx = 0;
        end
        if (dy < 0) begin
          sy -= dy;
          hh += dy;
          dy = 0;
        end
        if (dx + ww > fw) ww = fw - dx;
        if (dy + hh > fh) hh = fh - dy;
        if (ww <= 0 || hh <= 0) begin
          win_mode   = MODE_NONE;
          res.status = STAT_EMPTY;
        end else begin
          clip_sx  = 13'(sx);
          clip_sy  = 13'(sy);
          clip_w   = 12'(ww);
          clip_h   = 12'(hh);
          clip_dx  = 8'(dx);
          clip_dy  = 8'(dy);
          win_mode = (b.blend_enable && b.sprite_has_alpha) ? MODE_BLEND : MODE_COPY;
        end
      end
      REQ_SRC: begin
        ox = px - int'(clip_sx);
        oy = py - int'(clip_sy);
        tx = int'(clip_dx) + ox;
        ty = int'(clip_dy) + oy;
        if (win_mode == MODE_NONE || ox < 0 || oy < 0 ||
            ox >= int'(clip_w) || oy >= int'(clip_h)) begin
          res.status = STAT_SKIP;
        end else if (tx >= fw || ty >= fh) begin
          res.status = STAT_SKIP;
        end else begin
          slot = ty * FRAME_MAX_WIDTH + tx;
          a    = b.pixel_value[31:24];
          if (win_mode != MODE_BLEND || a == ALPHA_OPAQUE) begin
            frame_img[slot] = b.pixel_value;
          end else if (a == ALPHA_CLEAR) begin
            res.status = STAT_SKIP;
          end else begin
            // Premultiplied over; the destination keeps its own alpha byte.
            old_pix = frame_img[slot];
            inv     = 256 - int'(a);
            mixed   = old_pix;
            for (int ch = 0; ch < 3; ch++) begin
              mixed[8*ch +: 8] = 8'(int'(b.pixel_value[8*ch +: 8]) +
                                    ((int'(old_pix[8*ch +: 8]) * inv) >> 8));
            end
            frame_img[slot] = mixed;
          end
        end
      end
      default: begin
        if (px >= fw || py >= fh) begin
          res.status = STAT_SKIP;
        end else if (kind == REQ_WRITE) begin
          frame_img[py * FRAME_MAX_WIDTH + px] = b.pixel_value;
        end else begin
          res.pixel = frame_img[py * FRAME_MAX_WIDTH + px];
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      frame_w_reg = 9'd256;
      frame_h_reg = 9'd256;
      clip_sx     = '0;
      clip_sy     = '0;
      clip_w      = '0;
      clip_h      = '0;
      clip_dx     = '0;
      clip_dy     = '0;
      win_mode    = MODE_NONE;
      pending_outcomes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          FRAME_W_ADDR: frame_w_reg = pwdata[8:0];
          FRAME_H_ADDR: frame_h_reg = pwdata[8:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pending_outcomes.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing outstanding, status %0d",
                                  out_tuser));
        end else begin
          want = pending_outcomes.pop_front();
          if (out_tuser !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", out_tuser, want.status));
          if (out_tdata !== want.pixel)
            flag_mismatch($sformatf("read value %08h, wanted %08h", out_tdata, want.pixel));
        end
      end
      if (in_tvalid && in_tready)
        pending_outcomes.push_back(predict_outcome(req_t'(in_tuser), beat_t'(in_tdata)));
    end
  end

  always @(posedge run_done) begin
    if (pending_outcomes.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived",
                              pending_outcomes.size()));
  end

endmodule

@@ verif/sprite_blit_alpha_clip_unit_tb.sv @@
`timescale 1ns / 1ps
module sprite_blit_alpha_clip_unit_tb;
  import sba_pkg::*;

  localparam int CLR_W       = 16;
  localparam int CLR_H       = 8;
  localparam int REG_FRAME_W = 0;
  localparam int REG_FRAME_H = 1;
  localparam int PHASES      = 7;
  localparam int PHASE_BEATS = 34;
  localparam int LIMIT       = 200000;

  typedef struct packed {
    logic [3:0]  fill;
    logic [31:0] pixel_value;
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
    logic        sprite_has_alpha;
    logic        blend_enable;
    logic [12:0] win_dst_y;
    logic [12:0] win_dst_x;
    logic [11:0] win_height;
    logic [11:0] win_width;
    logic [11:0] win_src_y;
    logic [11:0] win_src_x;
  } beat_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = REQ_READ;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         psel       = 1'b0;
  logic         penable    = 1'b0;
  logic         pwrite     = 1'b0;
  logic [2:0]   paddr      = '0;
  logic [31:0]  pwdata     = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         run_done   = 1'b0;
  int           mismatches;

  int sent         = 0;
  int received     = 0;
  int cycle_count  = 0;
  int stall_left   = 0;
  bit calm         = 1'b0;
  int act_w        = 256;
  int act_h        = 256;
  int settings     = 1;
  int kind_count [4];
  int win_sx, win_sy, win_w, win_h;
  bit win_blend    = 1'b0;

  sprite_blit_alpha_clip_unit i_dut (.*);

  blit_outcome_checker i_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stall bursts, none once the run has gone calm.
  always @(negedge clk) begin
    if (stall_left == 0 && !calm && rst_n && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 9);
    out_tready = (stall_left == 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) received <= received + 1;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run timed out after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic beat_t noise_beat();
    logic [159:0] raw;
    beat_t        b;
    raw    = {$urandom, $urandom, $urandom, $urandom, $urandom};
    b      = raw[135:0];
    b.fill = '0;
    return b;
  endfunction

  task automatic push_beat(req_t kind, beat_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    sent++;
    kind_count[kind]++;
  endtask

  // Lower valid and hold off until every outstanding result beat is back.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sent != received) @(posedge clk);
  endtask

  task automatic reg_write(int idx, logic [8:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(4 * idx);
    pwdata  = {23'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_frame(int w, int h);
    drain();
    reg_write(REG_FRAME_W, 9'(w));
    reg_write(REG_FRAME_H, 9'(h));
    act_w = (w == 0) ? 1 : ((w > FRAME_MAX_WIDTH) ? FRAME_MAX_WIDTH : w);
    act_h = (h == 0) ? 1 : ((h > FRAME_MAX_HEIGHT) ? FRAME_MAX_HEIGHT : h);
    settings++;
  endtask

  task automatic frame_op(req_t kind, int x, int y, logic [31:0] value);
    beat_t b;
    b             = noise_beat();
    b.pixel_x     = 12'(x);
    b.pixel_y     = 12'(y);
    b.pixel_value = value;
    push_beat(kind, b);
  endtask

  task automatic sprite_px(int x, int y, logic [31:0] value);
    frame_op(REQ_SRC, x, y, value);
  endtask

  task automatic start_window(int sx, int sy, int w, int h, int dx, int dy,
                              logic be, logic ha);
    beat_t b;
    b                  = noise_beat();
    b.win_src_x        = 12'(sx);
    b.win_src_y        = 12'(sy);
    b.win_width        = 12'(w);
    b.win_height       = 12'(h);
    b.win_dst_x        = 13'(dx);
    b.win_dst_y        = 13'(dy);
    b.blend_enable     = be;
    b.sprite_has_alpha = ha;
    win_sx    = sx;
    win_sy    = sy;
    win_w     = w;
    win_h     = h;
    win_blend = be && ha;
    push_beat(REQ_BEGIN, b);
  endtask

  // Sprite pixels around the last window, most of them landing inside it.
  task automatic pixel_run(int n);
    int          px, py, lim_x, lim_y;
    logic [31:0] value;
    for (int k = 0; k < n; k++) begin
      lim_x = (win_w > 40) ? 40 : win_w;
      lim_y = (win_h > 40) ? 40 : win_h;
      px    = win_sx + $urandom_range(0, lim_x + 3) - 2;
      py    = win_sy + $urandom_range(0, lim_y + 3) - 2;
      if ($urandom_range(0, 7) == 0) begin
        px = $urandom_range(0, 4095);
        py = $urandom_range(0, 4095);
      end
      px    = (px < 0) ? 0 : ((px > 4095) ? 4095 : px);
      py    = (py < 0) ? 0 : ((py > 4095) ? 4095 : py);
      value = $urandom;
      if (win_blend) begin
        case ($urandom_range(0, 3))
          0:       value[31:24] = ALPHA_CLEAR;
          1:       value[31:24] = ALPHA_OPAQUE;
          default: ;
        endcase
      end
      sprite_px(px, py, value);
    end
  endtask

  // Blending windows stay inside the region cleared at the start, so a blend
  // never reads a pixel that was not written first.
  task automatic random_window();
    int         pick, dx, dy, w, h;
    logic [1:0] flags;
    pick  = $urandom_range(0, 9);
    flags = 2'($urandom_range(0, 2));
    if (pick < 5) begin
      dx = $urandom_range(0, CLR_W + 3) - 4;
      dy = $urandom_range(0, CLR_H + 3) - 4;
      w  = $urandom_range(1, CLR_W - dx);
      h  = $urandom_range(1, CLR_H - dy);
      flags = 2'b11;
    end else if (pick < 8) begin
      dx = $urandom_range(0, act_w + 10) - 8;
      dy = $urandom_range(0, act_h + 10) - 8;
      w  = $urandom_range(1, 24);
      h  = $urandom_range(1, 24);
    end else if (pick == 8) begin
      dx = $urandom_range(0, 8191) - 4096;
      dy = $urandom_range(0, 8191) - 4096;
      w  = $urandom_range(0, 4095);
      h  = $urandom_range(0, 4095);
    end else begin
      dx = $urandom_range(0, 20) - 10;
      dy = $urandom_range(0, 20) - 10;
      w  = $urandom_range(0, 4095);
      h  = $urandom_range(0, 4095);
    end
    start_window($urandom_range(0, 4095), $urandom_range(0, 4095), w, h, dx, dy,
                 flags[1], flags[0]);
  endtask

  task automatic random_access(req_t kind);
    int x, y;
    if (kind == REQ_READ && $urandom_range(0, 2) != 0) begin
      x = $urandom_range(0, ((act_w < CLR_W) ? act_w : CLR_W) - 1);
      y = $urandom_range(0, ((act_h < CLR_H) ? act_h : CLR_H) - 1);
    end else if (kind == REQ_READ) begin
      // Out of range only, so nothing unwritten is ever read back.
      if ($urandom_range(0, 1) == 1) begin
        x = $urandom_range(act_w, 4095);
        y = $urandom_range(0, 4095);
      end else begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(act_h, 4095);
      end
    end else if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
    end else begin
      x = $urandom_range(0, act_w + 3);
      y = $urandom_range(0, act_h + 3);
    end
    frame_op(kind, x, y, $urandom);
  endtask

  initial begin
    int frame_w_plan [PHASES];
    int frame_h_plan [PHASES];
    int start_count, pick;
    frame_w_plan = '{256, 1, 511, 0, 256, 0, 256};
    frame_h_plan = '{256, 1, 511, 256, 0, 0, 256};
    frame_w_plan[5] = $urandom_range(2, 255);
    frame_h_plan[5] = $urandom_range(2, 255);
    foreach (kind_count[k]) kind_count[k] = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int y = 0; y < CLR_H; y++)
      for (int x = 0; x < CLR_W; x++)
        frame_op(REQ_WRITE, x, y, $urandom);

    frame_op(REQ_READ, 0, 0, 32'h0);
    frame_op(REQ_READ, 4095, 4095, 32'h0);
    frame_op(REQ_WRITE, 4095, 0, 32'h1234_5678);
    frame_op(REQ_WRITE, 0, 4095, 32'h0);
    frame_op(REQ_WRITE, 255, 255, 32'hFFFF_FFFF);
    frame_op(REQ_READ, 255, 255, 32'h0);
    sprite_px(0, 0, 32'hFFFF_FFFF);
    start_window(0, 0, 4095, 4095, -4096, -4096, 1'b1, 1'b1);
    start_window(4095, 4095, 16, 16, 4095, 4095, 1'b0, 1'b1);
    start_window(10, 10, 0, 5, 0, 0, 1'b1, 1'b0);
    // Whole sprite range at the origin, cut back to the frame.
    start_window(4095, 4095, 4095, 4095, 0, 0, 1'b1, 1'b0);
    sprite_px(4095, 4095, 32'h0);
    sprite_px(4094, 4095, 32'h8000_0000);
    // Corner above and left of the frame; the window shrinks to 2 by 3.
    start_window(0, 0, 4, 4, -2, -1, 1'b1, 1'b1);
    sprite_px(2, 1, 32'h00AB_CDEF);
    sprite_px(3, 1, 32'hFF11_2233);
    sprite_px(2, 2, 32'h8040_2010);
    sprite_px(3, 3, 32'h01FF_FFFF);
    sprite_px(4, 1, 32'hFFFF_FFFF);
    sprite_px(1, 1, 32'hFFFF_FFFF);
    frame_op(REQ_READ, 3, 1, 32'h0);
    frame_op(REQ_READ, 2, 2, 32'h0);
    frame_op(REQ_READ, 3, 3, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) set_frame(frame_w_plan[p], frame_h_plan[p]);
      if (p == PHASES - 1) calm = 1'b1;
      // The window from before the size change may now map off the frame.
      pixel_run(4);
      start_count = sent;
      while (sent - start_count < PHASE_BEATS) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          random_window();
          pixel_run($urandom_range(3, 15));
        end else if (pick < 6) begin
          pixel_run($urandom_range(3, 8));
        end else if (pick < 8) begin
          random_access(REQ_WRITE);
        end else begin
          random_access(REQ_READ);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    run_done = 1'b1;
    @(posedge clk);
    $display("Covered %0d frame size settings and %0d beats in %0d cycles.",
             settings, sent, cycle_count);
    $display("Beats: %0d window starts, %0d sprite pixels, %0d writes, %0d reads.",
             kind_count[REQ_BEGIN], kind_count[REQ_SRC], kind_count[REQ_WRITE],
             kind_count[REQ_READ]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
